>>> design/csq_pkg.sv
// Shared types and constants for the chi-square uniformity histogram test.
// Used by the bin cells, the sum-of-squares unit, the divider and the top level.
// No dependencies.
package csq_pkg;

  // Histogram geometry and field widths.
  localparam int BINS        = 100;
  localparam int SAMPLE_BITS = 16;
  localparam int CFG_W       = 16;
  localparam int CNT_W       = 16;
  localparam int EXPNUM_W    = 16;
  localparam int CHI_W       = 34;
  localparam int BIN_W       = $clog2(BINS);
  localparam int PROD_W      = SAMPLE_BITS + BIN_W;

  // Expected count E = length div BINS, found by a reciprocal multiply that is
  // exact for every CFG_W-bit length.
  localparam int EXP_W       = $clog2((2**CFG_W - 1) / BINS + 1);
  localparam int RECIP_SHIFT = CFG_W + $clog2(BINS);
  localparam int RECIP_W     = CFG_W + 1;
  localparam int RECIP_MUL   = (2**RECIP_SHIFT + BINS - 1) / BINS;
  localparam int LENPROD_W   = CFG_W + RECIP_W;

  // Sum of squares and the Q8 quotient.
  localparam int SQ_W        = 2 * CNT_W;
  localparam int ACC_W       = SQ_W + $clog2(BINS);
  localparam int Q_FRAC      = 8;
  localparam int DVD_W       = ACC_W + Q_FRAC;
  localparam int STEP_W      = $clog2(DVD_W);

  // Sweep: one shift per bin, then the three-stage square pipeline drains.
  localparam int SUMSQ_DEPTH = 3;
  localparam int SWEEP_LEN   = BINS + SUMSQ_DEPTH;
  localparam int SWP_W       = $clog2(SWEEP_LEN);

  localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(10000);
  localparam logic [CHI_W-1:0] CHI_MAX   = {CHI_W{1'b1}};

  // Control to the row of bin cells.
  typedef struct packed {
    logic inc;
    logic shift;
  } cell_ctl_t;

  // Control to the sum-of-squares unit.
  typedef struct packed {
    logic clr;
    logic feed;
  } sumsq_ctl_t;

  // Status from the divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DIVIDE
  } csq_state_t;

endpackage

>>> design/csq_cell.sv
// One histogram bin: a count that increments on a matching item and shifts
// toward the head of the chain during the end-of-experiment sweep.
// Depends on csq_pkg.
module csq_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  csq_pkg::cell_ctl_t         ctl_i,
  input  logic [csq_pkg::BIN_W-1:0]  bin_i,
  input  logic [csq_pkg::BIN_W-1:0]  id_i,
  input  logic [csq_pkg::CNT_W-1:0]  next_i,
  output logic [csq_pkg::CNT_W-1:0]  count_o
);
  import csq_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // Shift has priority; otherwise count an item that falls in this bin.
  always_comb begin
    count_nxt = count_r;
    priority if (ctl_i.shift) begin
      count_nxt = next_i;
    end else if (ctl_i.inc && (bin_i == id_i)) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count_o = count_r;

endmodule

>>> design/csq_sumsq.sv
// Sum of squared deviations from the expected count, one bin per cycle in a
// three-stage pipeline: absolute difference, square, accumulate.
// Depends on csq_pkg.
module csq_sumsq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  csq_pkg::sumsq_ctl_t        ctl_i,
  input  logic [csq_pkg::CNT_W-1:0]  count_i,
  input  logic [csq_pkg::EXP_W-1:0]  expect_i,
  output logic [csq_pkg::ACC_W-1:0]  acc_o
);
  import csq_pkg::*;

  logic             v1_r, v2_r;
  logic [CNT_W-1:0] diff_r;
  logic [SQ_W-1:0]  sq_r;
  logic [ACC_W-1:0] acc_r;
  logic [CNT_W-1:0] exp_ext;
  logic [CNT_W-1:0] diff_nxt;

  // Absolute difference between the bin count and E.
  always_comb begin
    exp_ext = CNT_W'(expect_i);
    if (count_i >= exp_ext) begin
      diff_nxt = count_i - exp_ext;
    end else begin
      diff_nxt = exp_ext - count_i;
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctl_i.feed;
      v2_r <= v1_r;
    end
  end

  // Difference and square stages.
  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
    sq_r   <= SQ_W'(diff_r) * SQ_W'(diff_r);
  end

  // Accumulator, cleared when an experiment ends.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl_i.clr) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(sq_r);
    end
  end

  assign acc_o = acc_r;

endmodule

>>> design/csq_div.sv
// Restoring divider, one quotient bit per cycle, for the Q8 chi-square value:
// (sum of squares << 8) / E.
// Depends on csq_pkg.
module csq_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start_i,
  input  logic [csq_pkg::DVD_W-1:0]  dividend_i,
  input  logic [csq_pkg::EXP_W-1:0]  divisor_i,
  output csq_pkg::div_stat_t         stat_o,
  output logic [csq_pkg::DVD_W-1:0]  quotient_o
);
  import csq_pkg::*;

  logic              running_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [EXP_W-1:0]  rem_r;
  logic [EXP_W-1:0]  div_r;
  logic [DVD_W-1:0]  quo_r;
  logic [EXP_W:0]    rem_sh;
  logic              q_bit;
  logic [EXP_W:0]    rem_sub;

  // Shift in the next dividend bit and trial-subtract the divisor.
  always_comb begin
    rem_sh  = {rem_r, quo_r[DVD_W-1]};
    q_bit   = (rem_sh >= {1'b0, div_r});
    rem_sub = q_bit ? (rem_sh - {1'b0, div_r}) : rem_sh;
  end

  // Control: run for DVD_W steps, then pulse done.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
      step_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        running_r <= 1'b1;
        step_r    <= STEP_W'(DVD_W - 1);
      end else if (running_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == '0) begin
          running_r <= 1'b0;
          done_r    <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r <= '0;
      div_r <= divisor_i;
      quo_r <= dividend_i;
    end else if (running_r) begin
      rem_r <= rem_sub[EXP_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], q_bit};
    end
  end

  assign stat_o.busy = running_r;
  assign stat_o.done = done_r;
  assign quotient_o  = quo_r;

  // The partial remainder always stays below the divisor.
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  // Done comes only after the last step.
  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (!running_r && $past(running_r)))
    else $error("divider done without a finished run");

endmodule

>>> design/uniformity_chi_square_test.sv
// Chi-square uniformity test: a sample is taken in each cycle in which start is high and busy is low.
// The item that ends an experiment raises busy while the bin chain is shifted
// through the square pipeline and the divider then forms the quotient.
// out_valid pulses for one cycle as busy falls; the receiver cannot stall.
// Synchronous active-low reset clears all bins, counters and the length to 10000.
module uniformity_chi_square_test (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [csq_pkg::SAMPLE_BITS-1:0]   in_sample,
  output logic                              out_valid,
  output logic [csq_pkg::EXPNUM_W-1:0]      out_experiment_number,
  output logic [csq_pkg::CHI_W-1:0]         out_chi_square_q8,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [csq_pkg::CFG_W-1:0]         cfg_data
);
  import csq_pkg::*;

  csq_state_t state_r, state_nxt;

  logic [CFG_W-1:0]     len_r;
  logic [EXP_W-1:0]     expect_r;
  logic [CFG_W-1:0]     seen_r;
  logic [EXPNUM_W-1:0]  exp_num_r;
  logic [SWP_W-1:0]     swp_cnt_r;
  logic                 out_valid_r;
  logic [EXPNUM_W-1:0]  out_num_r;
  logic [CHI_W-1:0]     out_chi_r;

  logic                 accept;
  logic                 exp_end;
  logic [CFG_W:0]       seen_inc;
  logic [CFG_W-1:0]     len_eff;
  logic [PROD_W-1:0]    bin_prod;
  logic [BIN_W-1:0]     bin_idx;
  logic [LENPROD_W-1:0] len_prod;
  logic [EXP_W-1:0]     expect_q;
  logic                 sweep_last;
  logic                 div_start;
  cell_ctl_t            cell_ctl;
  sumsq_ctl_t           sq_ctl;
  div_stat_t            div_stat;
  logic [ACC_W-1:0]     acc;
  logic [DVD_W-1:0]     quotient;
  logic [CNT_W-1:0]     chain [BINS+1];

  // Intake and the end-of-experiment test.
  always_comb begin
    accept   = start && (state_r == ST_IDLE);
    len_eff  = (len_r == '0) ? CFG_W'(1) : len_r;
    seen_inc = {1'b0, seen_r} + (CFG_W+1)'(1);
    exp_end  = (seen_inc >= {1'b0, len_eff});
    bin_prod = PROD_W'(in_sample) * PROD_W'(BINS);
    bin_idx  = bin_prod[PROD_W-1 -: BIN_W];
  end

  // Expected count by reciprocal multiply; zero is taken as one.
  always_comb begin
    len_prod = LENPROD_W'(len_r) * LENPROD_W'(RECIP_MUL);
    expect_q = len_prod[RECIP_SHIFT +: EXP_W];
  end

  // Configuration register and derived expected count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= LEN_RESET;
      expect_r <= EXP_W'(1);
    end else begin
      if (cfg_valid) begin
        len_r <= cfg_data;
      end
      expect_r <= (expect_q == '0) ? EXP_W'(1) : expect_q;
    end
  end

  assign cfg_ready = 1'b1;

  // Next-state logic.
  always_comb begin
    sweep_last = (swp_cnt_r == SWP_W'(SWEEP_LEN - 1));
    state_nxt  = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && exp_end) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (sweep_last) begin
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output logic of the sequencer.
  always_comb begin
    cell_ctl  = '0;
    sq_ctl    = '0;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cell_ctl.inc = accept;
        sq_ctl.clr   = accept && exp_end;
      end
      ST_SWEEP: begin
        cell_ctl.shift = (swp_cnt_r < SWP_W'(BINS));
        sq_ctl.feed    = (swp_cnt_r < SWP_W'(BINS));
        div_start      = sweep_last;
      end
      ST_DIVIDE: begin
      end
      default: begin
      end
    endcase
  end

  // State, counters and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seen_r      <= '0;
      exp_num_r   <= '0;
      swp_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (accept) begin
        seen_r <= exp_end ? '0 : seen_inc[CFG_W-1:0];
      end
      if (state_r == ST_SWEEP) begin
        swp_cnt_r <= sweep_last ? '0 : (swp_cnt_r + SWP_W'(1));
      end
      if ((state_r == ST_DIVIDE) && div_stat.done) begin
        out_valid_r <= 1'b1;
        exp_num_r   <= exp_num_r + EXPNUM_W'(1);
      end
    end
  end

  // Result payload, saturated to the output width.
  always_ff @(posedge clk) begin
    if ((state_r == ST_DIVIDE) && div_stat.done) begin
      out_num_r <= exp_num_r;
      if (|quotient[DVD_W-1:CHI_W]) begin
        out_chi_r <= CHI_MAX;
      end else begin
        out_chi_r <= quotient[CHI_W-1:0];
      end
    end
  end

  // Row of bin cells; zeros enter at the tail so the sweep also clears them.
  assign chain[BINS] = '0;

  for (genvar g = 0; g < BINS; g++) begin : g_cell
    csq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (cell_ctl),
      .bin_i   (bin_idx),
      .id_i    (BIN_W'(g)),
      .next_i  (chain[g+1]),
      .count_o (chain[g])
    );
  end

  csq_sumsq u_sumsq (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (sq_ctl),
    .count_i  (chain[0]),
    .expect_i (expect_r),
    .acc_o    (acc)
  );

  csq_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i ({acc, Q_FRAC'(0)}),
    .divisor_i  (expect_r),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  assign busy                  = (state_r != ST_IDLE);
  assign out_valid             = out_valid_r;
  assign out_experiment_number = out_num_r;
  assign out_chi_square_q8     = out_chi_r;

  // The item that ends an experiment starts the sweep.
  a_end_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && exp_end) |=> (state_r == ST_SWEEP))
    else $error("experiment end did not start the sweep");

  // After the sweep every bin has been shifted out and cleared; the check looks at the head and tail bins.
  a_bins_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVIDE) |-> ((chain[0] == '0) && (chain[BINS-1] == '0)))
    else $error("bins not cleared after sweep");

  // The divider is never restarted while it is still running.
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // A result comes only out of the divide phase.
  a_result_from_divide: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r == ST_DIVIDE) && (state_r == ST_IDLE)))
    else $error("result outside the divide phase");

endmodule
